// ===== hdl/sem_pkg.sv =====
// ----------------------------------------------------------------------------
// sem_pkg
// Shared widths, constants, register indexes and types of the Sobel edge
// magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int PIXEL_W   = 8;
  localparam int MAG_W     = 8;
  localparam int ROW_W     = 12;
  localparam int COL_W     = 10;
  localparam int WIDTH_W   = 11;
  localparam int HEIGHT_W  = 12;
  localparam int SUM_W     = 21;
  localparam int ROOT_W    = 11;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam int MAX_LINE_DEFAULT = 1024;
  localparam int MIN_DIM          = 3;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [MAG_W-1:0]    MAG_MAX      = 8'd255;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    F_IDLE,
    F_WRITE,
    F_GRAD,
    F_SQUARE,
    F_HAND
  } sem_front_state_t;

  typedef enum logic [1:0] {
    R_IDLE,
    R_RUN,
    R_DONE
  } sem_root_state_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } sem_job_t;

endpackage

// ===== hdl/sem_ifs.sv =====
// ----------------------------------------------------------------------------
// sem_ifs
// Valid/ready channels of the Sobel edge magnitude block: the pixel input
// word and the edge result word.
// ----------------------------------------------------------------------------
interface sem_pixel_if import sem_pkg::*;;
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface sem_result_if import sem_pkg::*;;
  logic             valid;
  logic             ready;
  logic [MAG_W-1:0] magnitude;
  logic [ROW_W-1:0] center_row;
  logic [COL_W-1:0] center_col;
  logic             frame_last;

  modport source (output valid, output magnitude, output center_row,
                  output center_col, output frame_last, input ready);
  modport sink (input valid, input magnitude, input center_row,
                input center_col, input frame_last, output ready);
endinterface

// ===== hdl/sem_front.sv =====
// ----------------------------------------------------------------------------
// sem_front
// Configuration registers, raster position, line memory, 3x3 window and
// gradient datapath. Hands the squared gradient sum of each interior center
// to the square root unit.
// ----------------------------------------------------------------------------
module sem_front import sem_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  sem_pixel_if.sink             pixels,
  output sem_job_t              job,
  output logic                  job_valid,
  input  logic                  job_ready
);

  localparam int ADDR_W = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam int CMP_W  = (ADDR_W + 1 > WIDTH_W) ? ADDR_W + 1 : WIDTH_W;
  localparam int GRAD_W = PIXEL_W + 3;
  localparam int SQ_W   = SUM_W - 1;
  localparam int PROD_W = 2 * GRAD_W;

  sem_front_state_t state, state_next;

  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;
  logic [ADDR_W-1:0]   col, col_next;
  logic [ROW_W-1:0]    row, row_next;

  logic [CMP_W-1:0]    eff_w, col_ext, cur_c, c_plus;
  logic [ROW_W-1:0]    eff_h, cur_r;
  logic [ROW_W:0]      row_inc, r_plus;
  logic                wrap, produce, accept;

  logic [2*PIXEL_W-1:0] lines [MAX_LINE];
  logic [2*PIXEL_W-1:0] line_rd;
  logic [ADDR_W-1:0]    addr;
  logic [PIXEL_W-1:0]   px;
  logic                 produce_q;
  logic [ROW_W-1:0]     job_row;
  logic [COL_W-1:0]     job_col;
  logic                 job_last;

  logic [PIXEL_W-1:0]       win [3][3];
  logic signed [GRAD_W-1:0] gx, gy;
  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic [SQ_W-1:0]          sq_x, sq_y;

  function automatic logic [PIXEL_W+1:0] weigh(input logic [PIXEL_W-1:0] a,
                                               input logic [PIXEL_W-1:0] b,
                                               input logic [PIXEL_W-1:0] c);
    weigh = (PIXEL_W+2)'(a) + {1'b0, b, 1'b0} + (PIXEL_W+2)'(c);
  endfunction

  assign accept = pixels.valid && pixels.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_w = CMP_W'(image_width);
    if (eff_w < CMP_W'(MIN_DIM)) begin
      eff_w = CMP_W'(MIN_DIM);
    end else if (eff_w > CMP_W'(MAX_LINE)) begin
      eff_w = CMP_W'(MAX_LINE);
    end
    eff_h = (image_height < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : image_height;

    col_ext = CMP_W'(col);
    wrap    = col_ext >= eff_w;
    cur_c   = wrap ? '0 : col_ext;
    row_inc = {1'b0, row} + (ROW_W+1)'(wrap);
    cur_r   = (row_inc >= {1'b0, eff_h}) ? '0 : row_inc[ROW_W-1:0];

    c_plus = cur_c + CMP_W'(1);
    r_plus = {1'b0, cur_r} + (ROW_W+1)'(1);
    if (c_plus >= eff_w) begin
      col_next = '0;
      row_next = (r_plus >= {1'b0, eff_h}) ? '0 : r_plus[ROW_W-1:0];
    end else begin
      col_next = c_plus[ADDR_W-1:0];
      row_next = cur_r;
    end
    produce = (cur_r >= ROW_W'(2)) && (cur_c >= CMP_W'(2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_rd   <= lines[cur_c[ADDR_W-1:0]];
      addr      <= cur_c[ADDR_W-1:0];
      px        <= pixels.pixel;
      produce_q <= produce;
      job_row   <= cur_r - ROW_W'(1);
      job_col   <= COL_W'(cur_c - CMP_W'(1));
      job_last  <= (cur_r == eff_h - ROW_W'(1)) && (cur_c == eff_w - CMP_W'(1));
    end
    if (state == F_WRITE) begin
      lines[addr] <= {line_rd[PIXEL_W-1:0], px};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win[k][j] <= '0;
        end
      end
    end else if (state == F_WRITE) begin
      for (int k = 0; k < 3; k++) begin
        win[k][0] <= win[k][1];
        win[k][1] <= win[k][2];
      end
      win[0][2] <= line_rd[2*PIXEL_W-1:PIXEL_W];
      win[1][2] <= line_rd[PIXEL_W-1:0];
      win[2][2] <= px;
    end
  end

  assign prod_x = gx * gx;
  assign prod_y = gy * gy;

  always_ff @(posedge clk) begin
    if (state == F_GRAD) begin
      gx <= $signed({1'b0, weigh(win[0][0], win[1][0], win[2][0])})
          - $signed({1'b0, weigh(win[0][2], win[1][2], win[2][2])});
      gy <= $signed({1'b0, weigh(win[2][0], win[2][1], win[2][2])})
          - $signed({1'b0, weigh(win[0][0], win[0][1], win[0][2])});
    end
    if (state == F_SQUARE) begin
      sq_x <= prod_x[SQ_W-1:0];
      sq_y <= prod_y[SQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    pixels.ready = 1'b0;
    job_valid    = 1'b0;
    unique case (state)
      F_IDLE: begin
        pixels.ready = 1'b1;
        if (pixels.valid) begin
          state_next = F_WRITE;
        end
      end
      F_WRITE: begin
        state_next = produce_q ? F_GRAD : F_IDLE;
      end
      F_GRAD: begin
        state_next = F_SQUARE;
      end
      F_SQUARE: begin
        state_next = F_HAND;
      end
      F_HAND: begin
        job_valid = 1'b1;
        if (job_ready) begin
          state_next = F_IDLE;
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

  assign job.sum  = {1'b0, sq_x} + {1'b0, sq_y};
  assign job.row  = job_row;
  assign job.col  = job_col;
  assign job.last = job_last;

  a_job_holds: assert property (@(posedge clk) disable iff (rst)
    job_valid && !job_ready |=> job_valid && $stable(job))
    else $error("Job changed while waiting for the root unit.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !pixels.ready)
    else $error("A second word was taken before the line memory update.");

  a_interior_only: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> job.row != '0 && job.col != '0)
    else $error("Job issued for a border center.");

endmodule

// ===== hdl/sem_root.sv =====
// ----------------------------------------------------------------------------
// sem_root
// Iterative integer square root, two radicand bits per cycle, followed by
// scaling, saturation and the output register of the result channel.
// ----------------------------------------------------------------------------
module sem_root import sem_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  sem_job_t    job,
  input  logic        job_valid,
  output logic        job_ready,
  sem_result_if.source edges
);

  localparam int OP_W  = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 3;
  localparam int CNT_W = $clog2(ROOT_W);
  localparam int SC_W  = ROOT_W - 2;

  sem_root_state_t state, state_next;

  logic [OP_W-1:0]   op;
  logic [REM_W-1:0]  rem, rem_sh, trial;
  logic [ROOT_W-1:0] root;
  logic [CNT_W-1:0]  count;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic              last;
  logic              take, load, out_valid;
  logic [SC_W-1:0]   scaled;
  logic [MAG_W-1:0]  mag;

  assign take   = job_valid && job_ready;
  assign rem_sh = {rem[REM_W-3:0], op[OP_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign scaled = root[ROOT_W-1:2];
  assign mag    = (scaled > SC_W'(MAG_MAX)) ? MAG_MAX : MAG_W'(scaled);
  assign load   = (state == R_DONE) && (!out_valid || edges.ready);

  always_ff @(posedge clk) begin
    if (take) begin
      op    <= OP_W'(job.sum);
      rem   <= '0;
      root  <= '0;
      count <= CNT_W'(ROOT_W - 1);
      row   <= job.row;
      col   <= job.col;
      last  <= job.last;
    end else if (state == R_RUN) begin
      op    <= op << 2;
      count <= count - CNT_W'(1);
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    job_ready  = 1'b0;
    unique case (state)
      R_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          state_next = R_RUN;
        end
      end
      R_RUN: begin
        if (count == '0) begin
          state_next = R_DONE;
        end
      end
      R_DONE: begin
        if (load) begin
          state_next = R_IDLE;
        end
      end
      default: begin
        state_next = R_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (edges.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      edges.magnitude  <= mag;
      edges.center_row <= row;
      edges.center_col <= col;
      edges.frame_last <= last;
    end
  end

  assign edges.valid = out_valid;

  a_run_after_take: assert property (@(posedge clk) disable iff (rst)
    take |=> state == R_RUN && !job_ready)
    else $error("Root unit did not start on a taken job.");

  a_out_drains: assert property (@(posedge clk) disable iff (rst)
    out_valid && edges.ready && !load |=> !out_valid)
    else $error("Output word repeated after it was taken.");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid && state == R_IDLE)
    else $error("Finished root was not moved to the output register.");

endmodule

// ===== hdl/sobel_edge_magnitude_top.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_top
// Streaming 3x3 Sobel edge magnitude over a raster of grayscale pixels.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the pixel channel; every pixel that
// completes a window around an interior center yields one word with the
// magnitude floor(sqrt(gx*gx + gy*gy) / 4), saturated at 255, its center
// position and an end-of-frame flag. A pixel's two-pixel line memory entry
// is read as the pixel is taken and written back in the cycle after; a
// border pixel then passes the write state only, an interior pixel also
// the gradient, square and hand-off states, and no pixel is taken before
// the last is through. The square root unit resolves two radicand bits
// per cycle while later pixels enter but takes a job only when idle; a
// word waiting in the output register holds back the next result, the
// hand-off and the input. The line memory needs no clearing after reset:
// the first two lines of each frame produce no result. Image width and
// height are written through the configuration port between frames.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_top import sem_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  sem_pixel_if.sink             pixels,
  sem_result_if.source          edges
);

  sem_job_t job;
  logic     job_valid;
  logic     job_ready;

  sem_front #(
    .MAX_LINE (MAX_LINE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pixels),
    .job       (job),
    .job_valid (job_valid),
    .job_ready (job_ready)
  );

  sem_root u_root (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .edges     (edges)
  );

endmodule
